/* hdl/wfs_pkg.sv */
package wfs_pkg;

	localparam int PERIOD_W = 16;
	localparam int ERR_W    = 13;
	localparam int RATE_W   = 12;
	localparam int GAIN_W   = 8;
	localparam int CFG_IDX_W = 3;

	localparam int ERR_MAX = 2 ** (ERR_W - 1) - 1;
	localparam int ERR_MIN = -(2 ** (ERR_W - 1));

	// wall-follow thresholds
	localparam int WALL_MID   = 55;
	localparam int RIGHT_SEEN = 25;
	localparam int LEFT_SEEN  = 20;
	localparam int DEADBAND   = 5;
	localparam int BASE_RESET = 18000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_RATE    = 3'd0,
		REG_ACCEL_LIMIT   = 3'd1,
		REG_DECEL_RATE    = 3'd2,
		REG_DECEL_LIMIT   = 3'd3,
		REG_PROP_GAIN     = 3'd4,
		REG_DERIV_GAIN    = 3'd5,
		REG_RELOAD_PERIOD = 3'd6
	} cfg_reg_t;

endpackage

/* hdl/wall_follow_pd_steering_top.sv */
// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall  left_reading, right_reading, ramp_down, reload_base
// out       out  out_valid / out_stall left_period, right_period, steer_error, base_period
// cfg       in   cfg_valid / cfg_ready cfg_index, cfg_data (ready always high)
//
// One request per clock, sustained while out_stall stays low. The input register
// holds the clamped steering error, the result register takes the ramp and PD
// step (two small multiplies and the saturating adds).
// Reset restores all config registers, base period 18000 and last error 0.
// A stalled result holds; the input register keeps taking requests until it
// is full behind the stalled result, then in_stall rises.
module wall_follow_pd_steering_top #(
	parameter int SENSOR_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [SENSOR_BITS-1:0]               left_reading,
	input  logic [SENSOR_BITS-1:0]               right_reading,
	input  logic                                 ramp_down,
	input  logic                                 reload_base,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [wfs_pkg::PERIOD_W-1:0]         left_period,
	output logic [wfs_pkg::PERIOD_W-1:0]         right_period,
	output logic signed [wfs_pkg::ERR_W-1:0]     steer_error,
	output logic [wfs_pkg::PERIOD_W-1:0]         base_period,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [wfs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wfs_pkg::PERIOD_W-1:0]         cfg_data
);
	import wfs_pkg::*;

	// error math needs two bits over the reading: sign and subtract headroom
	localparam int EW    = SENSOR_BITS + 2;
	localparam int PD_W  = ERR_W + GAIN_W + 3;
	localparam int SUM_W = PD_W + 1;

	// config registers
	logic [RATE_W-1:0]   accel_rate_q, decel_rate_q;
	logic [PERIOD_W-1:0] accel_limit_q, decel_limit_q, reload_period_q;
	logic [GAIN_W-1:0]   prop_gain_q, deriv_gain_q;

	// loop state
	logic [PERIOD_W-1:0]     base_q;
	logic signed [ERR_W-1:0] last_err_q;

	// input stage
	logic                    valid_s1;
	logic signed [ERR_W-1:0] err_s1;
	logic                    down_s1, reload_s1;

	logic advance;
	assign advance   = !out_valid || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_rate_q    <= RATE_W'(10);
			accel_limit_q   <= PERIOD_W'(16000);
			decel_rate_q    <= RATE_W'(50);
			decel_limit_q   <= PERIOD_W'(20000);
			prop_gain_q     <= GAIN_W'(1);
			deriv_gain_q    <= '0;
			reload_period_q <= PERIOD_W'(BASE_RESET);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_ACCEL_RATE:    accel_rate_q    <= cfg_data[RATE_W-1:0];
				REG_ACCEL_LIMIT:   accel_limit_q   <= cfg_data;
				REG_DECEL_RATE:    decel_rate_q    <= cfg_data[RATE_W-1:0];
				REG_DECEL_LIMIT:   decel_limit_q   <= cfg_data;
				REG_PROP_GAIN:     prop_gain_q     <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:    deriv_gain_q    <= cfg_data[GAIN_W-1:0];
				REG_RELOAD_PERIOD: reload_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- steering error from the raw readings ----
	logic signed [EW-1:0]    rd_s, ld_s, raw_err;
	logic signed [31:0]      raw_x;
	logic signed [ERR_W-1:0] err_c, err_d;

	always_comb begin
		rd_s = $signed({2'b00, right_reading});
		ld_s = $signed({2'b00, left_reading});
		if (right_reading > RIGHT_SEEN) begin
			raw_err = rd_s - $signed(EW'(WALL_MID));
		end else if (left_reading > LEFT_SEEN) begin
			raw_err = $signed(EW'(WALL_MID)) - ld_s;
		end else begin
			raw_err = '0;
		end
		raw_x = 32'(raw_err);
		if (raw_x > ERR_MAX) begin
			err_c = ERR_W'(ERR_MAX);
		end else if (raw_x < ERR_MIN) begin
			err_c = ERR_W'(ERR_MIN);
		end else begin
			err_c = raw_x[ERR_W-1:0];
		end
		// deadband: small errors count as centered
		if (err_c > -DEADBAND && err_c < DEADBAND) begin
			err_d = '0;
		end else begin
			err_d = err_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			err_s1    <= err_d;
			down_s1   <= ramp_down;
			reload_s1 <= reload_base;
		end
	end

	// ---- ramp of the base period ----
	logic [PERIOD_W:0]   up_sum;
	logic [PERIOD_W-1:0] base_nx;

	always_comb begin
		up_sum = {1'b0, base_q} + (PERIOD_W + 1)'(decel_rate_q);
		base_nx = base_q;
		if (reload_s1) begin
			base_nx = reload_period_q;
		end else if (down_s1) begin
			if (base_q < decel_limit_q) begin
				base_nx = up_sum[PERIOD_W] ? '1 : up_sum[PERIOD_W-1:0];
			end
		end else begin
			if (base_q > accel_limit_q) begin
				base_nx = (PERIOD_W'(accel_rate_q) > base_q) ? '0
				          : base_q - PERIOD_W'(accel_rate_q);
			end
		end
	end

	// ---- PD term and motor periods ----
	logic signed [ERR_W:0]          diff;
	logic signed [ERR_W+GAIN_W:0]   p_term;
	logic signed [ERR_W+GAIN_W+1:0] d_term;
	logic signed [PD_W-1:0]         pd;
	logic signed [SUM_W-1:0]        base_x, l_sum, r_sum;

	function automatic logic [PERIOD_W-1:0] sat_period(input logic signed [SUM_W-1:0] v);
		logic [PERIOD_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed(SUM_W'({PERIOD_W{1'b1}}))) begin
			r = '1;
		end else begin
			r = v[PERIOD_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		diff   = {err_s1[ERR_W-1], err_s1} - {last_err_q[ERR_W-1], last_err_q};
		p_term = err_s1 * $signed({1'b0, prop_gain_q});
		d_term = diff * $signed({1'b0, deriv_gain_q});
		pd     = PD_W'(p_term) + PD_W'(d_term);
		base_x = $signed(SUM_W'(base_nx));
		l_sum  = base_x - SUM_W'(pd);
		r_sum  = base_x + SUM_W'(pd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid  <= 1'b0;
			base_q     <= PERIOD_W'(BASE_RESET);
			last_err_q <= '0;
		end else if (advance) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				base_q     <= base_nx;
				last_err_q <= err_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			left_period  <= sat_period(l_sum);
			right_period <= sat_period(r_sum);
			steer_error  <= err_s1;
			base_period  <= base_nx;
		end
	end

endmodule

/* hdl/wfs_checker.sv */
module wfs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [wfs_pkg::PERIOD_W-1:0]     left_period,
	input logic [wfs_pkg::PERIOD_W-1:0]     right_period,
	input logic signed [wfs_pkg::ERR_W-1:0] steer_error,
	input logic [wfs_pkg::PERIOD_W-1:0]     base_period
);
	import wfs_pkg::*;

	// a stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// and keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(left_period) && $stable(right_period)
			&& $stable(base_period) && $stable(steer_error))
		else $error("stalled result changed");

	// deadband leaves no small nonzero error
	a_deadband: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && steer_error > -DEADBAND && steer_error < DEADBAND
			|-> steer_error == '0)
		else $error("error inside deadband not zeroed");

	// motor periods split around the base, one side at or below it
	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_period <= base_period) || (right_period <= base_period))
		else $error("both motor periods above base");

endmodule

bind wall_follow_pd_steering_top wfs_checker u_wfs_checker (.*);

/* test/wall_follow_pd_steering_top_test.sv */
`timescale 1ns / 1ps

typedef struct packed {
	logic [15:0]        left_period;
	logic [15:0]        right_period;
	logic signed [12:0] steer_error;
	logic [15:0]        base_period;
} steer_result_t;

class steer_scoreboard;
	logic [11:0] accel_rate;
	logic [15:0] accel_limit;
	logic [11:0] decel_rate;
	logic [15:0] decel_limit;
	logic [7:0]  prop_gain;
	logic [7:0]  deriv_gain;
	logic [15:0] reload_period;
	int          base_now;
	int          prev_err;
	steer_result_t expected_q[$];
	int          mismatches;

	function new();
		accel_rate    = 12'd10;
		accel_limit   = 16'd16000;
		decel_rate    = 12'd50;
		decel_limit   = 16'd20000;
		prop_gain     = 8'd1;
		deriv_gain    = 8'd0;
		reload_period = 16'(wfs_pkg::BASE_RESET);
		base_now      = wfs_pkg::BASE_RESET;
		prev_err      = 0;
		mismatches    = 0;
	endfunction

	function int clip_period(int v);
		if (v < 0)
			return 0;
		if (v > 65535)
			return 65535;
		return v;
	endfunction

	function void write_reg(logic [2:0] idx, logic [15:0] data);
		case (idx)
			wfs_pkg::REG_ACCEL_RATE:    accel_rate    = data[11:0];
			wfs_pkg::REG_ACCEL_LIMIT:   accel_limit   = data;
			wfs_pkg::REG_DECEL_RATE:    decel_rate    = data[11:0];
			wfs_pkg::REG_DECEL_LIMIT:   decel_limit   = data;
			wfs_pkg::REG_PROP_GAIN:     prop_gain     = data[7:0];
			wfs_pkg::REG_DERIV_GAIN:    deriv_gain    = data[7:0];
			wfs_pkg::REG_RELOAD_PERIOD: reload_period = data;
			default: ;
		endcase
	endfunction

	// one sample in, one expected result queued
	function void note_sample(logic [11:0] l, logic [11:0] r, logic down, logic reload);
		int b, err, mag, pd, li, ri;
		steer_result_t e;
		li = int'(l);
		ri = int'(r);
		b = base_now;
		if (reload)
			b = int'(reload_period);
		else if (down) begin
			if (b < int'(decel_limit))
				b = clip_period(b + int'(decel_rate));
		end else if (b > int'(accel_limit))
			b = clip_period(b - int'(accel_rate));
		base_now = b;

		if (ri > wfs_pkg::RIGHT_SEEN)
			err = ri - wfs_pkg::WALL_MID;
		else if (li > wfs_pkg::LEFT_SEEN)
			err = wfs_pkg::WALL_MID - li;
		else
			err = 0;
		if (err > wfs_pkg::ERR_MAX)
			err = wfs_pkg::ERR_MAX;
		if (err < wfs_pkg::ERR_MIN)
			err = wfs_pkg::ERR_MIN;
		mag = (err < 0) ? -err : err;
		if (mag < wfs_pkg::DEADBAND)
			err = 0;

		pd = err * int'(prop_gain) + (err - prev_err) * int'(deriv_gain);
		prev_err = err;

		e.left_period  = 16'(clip_period(b - pd));
		e.right_period = 16'(clip_period(b + pd));
		e.steer_error  = err[12:0];
		e.base_period  = b[15:0];
		expected_q.push_back(e);
	endfunction

	function void check_result(logic [15:0] lp, logic [15:0] rp, logic signed [12:0] se,
			logic [15:0] bp);
		steer_result_t e;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with no request pending: left %0d right %0d err %0d base %0d",
					$realtime, lp, rp, se, bp);
			return;
		end
		e = expected_q.pop_front();
		if (e.left_period !== lp || e.right_period !== rp || e.steer_error !== se
				|| e.base_period !== bp) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: exp left %0d right %0d err %0d base %0d, got left %0d right %0d err %0d base %0d",
					$realtime, e.left_period, e.right_period, e.steer_error, e.base_period,
					lp, rp, se, bp);
		end
	endfunction
endclass

module wall_follow_pd_steering_top_test;
	import wfs_pkg::*;

	// cycles without any handshake before the run is called hung
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 115;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [11:0]                left_reading;
	logic [11:0]                right_reading;
	logic                       ramp_down;
	logic                       reload_base;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [PERIOD_W-1:0]        left_period;
	logic [PERIOD_W-1:0]        right_period;
	logic signed [ERR_W-1:0]    steer_error;
	logic [PERIOD_W-1:0]        base_period;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [PERIOD_W-1:0]        cfg_data;

	steer_scoreboard sb = new();

	int   gap_pct = 0;      // sender idle chance, percent per request
	int   stall_pct = 0;    // receiver stall chance, percent per cycle
	int   quiet_cycles = 0;
	logic slowing = 1'b0;   // sticky ramp direction for random traffic

	wall_follow_pd_steering_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.left_reading  (left_reading),
		.right_reading (right_reading),
		.ramp_down     (ramp_down),
		.reload_base   (reload_base),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.left_period   (left_period),
		.right_period  (right_period),
		.steer_error   (steer_error),
		.base_period   (base_period),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// random back-pressure on the result side
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Sample every handshake at the edge. Inputs are driven by NBAs and the
	// DUT registers update in the NBA region, so these are pre-edge values.
	// Config writes go to the predictor here too, so it tracks exactly what
	// the block saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.note_sample(left_reading, right_reading, ramp_down, reload_base);
			if (out_valid && !out_stall)
				sb.check_result(left_period, right_period, steer_error, base_period);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// watchdog: nothing moved for too long
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// Present one request and hold it until taken. Valid stays high on
	// return so back-to-back requests never drop it within a time step.
	task automatic send_sample(logic [11:0] l, logic [11:0] r, logic down, logic reload);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		left_reading  <= l;
		right_reading <= r;
		ramp_down     <= down;
		reload_base   <= reload;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic program_regs(logic [11:0] a_rate, logic [15:0] a_lim, logic [11:0] d_rate,
			logic [15:0] d_lim, logic [7:0] p_gain, logic [7:0] d_gain, logic [15:0] reload_val);
		write_reg(REG_ACCEL_RATE, 16'(a_rate));
		write_reg(REG_ACCEL_LIMIT, a_lim);
		write_reg(REG_DECEL_RATE, 16'(d_rate));
		write_reg(REG_DECEL_LIMIT, d_lim);
		write_reg(REG_PROP_GAIN, 16'(p_gain));
		write_reg(REG_DERIV_GAIN, 16'(d_gain));
		write_reg(REG_RELOAD_PERIOD, reload_val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid, let every pending result come out, then cover the pipe depth
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly near the wall thresholds, some full scale, some exact edges
	function automatic logic [11:0] pick_reading();
		int edges[10] = '{0, 20, 21, 25, 26, 50, 51, 59, 60, 4095};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 12'($urandom_range(0, 100));
			6, 7, 8:          return 12'($urandom);
			default:          return 12'(edges[$urandom_range(0, 9)]);
		endcase
	endfunction

	function automatic logic [7:0] pick_gain();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 6));
	endfunction

	task automatic run_random(int count);
		repeat (count) begin
			// ramp direction sticks for a while so the base reaches its limits
			if ($urandom_range(0, 15) == 0)
				slowing = ~slowing;
			send_sample(pick_reading(), pick_reading(), slowing, $urandom_range(0, 24) == 0);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		left_reading  = '0;
		right_reading = '0;
		ramp_down     = 1'b0;
		reload_base   = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles a little, receiver stalls a lot
		gap_pct   = 11;
		stall_pct = 45;

		// directed, reset config (P gain 1, no D term)
		send_sample(12'd0, 12'd0, 1'b0, 1'b0);         // no wall, accel step
		send_sample(12'd0, 12'd26, 1'b0, 1'b0);        // right just seen
		send_sample(12'd21, 12'd25, 1'b0, 1'b0);       // left just seen, right not
		send_sample(12'd20, 12'd25, 1'b0, 1'b0);       // neither seen
		send_sample(12'd0, 12'd59, 1'b0, 1'b0);        // inside deadband
		send_sample(12'd0, 12'd60, 1'b0, 1'b0);        // deadband edge
		send_sample(12'd0, 12'd51, 1'b0, 1'b0);
		send_sample(12'd0, 12'd50, 1'b0, 1'b0);
		send_sample(12'd59, 12'd0, 1'b1, 1'b0);        // left side deadband, ramp down
		send_sample(12'd60, 12'd0, 1'b1, 1'b0);
		send_sample(12'd51, 12'd0, 1'b1, 1'b0);
		send_sample(12'd50, 12'd0, 1'b1, 1'b0);
		send_sample(12'd0, 12'd4095, 1'b1, 1'b0);      // largest positive error
		send_sample(12'd4095, 12'd0, 1'b0, 1'b0);      // largest negative error
		send_sample(12'd4095, 12'd4095, 1'b0, 1'b0);   // right side wins
		send_sample(12'hAAA, 12'h555, 1'b0, 1'b0);
		send_sample(12'h555, 12'hAAA, 1'b1, 1'b0);
		send_sample(12'hAAA, 12'd0, 1'b0, 1'b0);
		send_sample(12'd30, 12'd0, 1'b1, 1'b1);        // reload wins over ramp down
		send_sample(12'd0, 12'd100, 1'b0, 1'b1);       // plain reload
		send_sample(12'd0, 12'd0, 1'b1, 1'b0);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 2) begin
				gap_pct   = 45;
				stall_pct = 11;
			end else if (phase == 4) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			case (phase)
				// everything at max: ramp saturates both ways, PD saturates outputs
				0: program_regs(12'd4095, 16'd0, 12'd4095, 16'd65535, 8'd255, 8'd255, 16'd65535);
				// everything at zero: ramp frozen, no steering
				1: program_regs(12'd0, 16'd0, 12'd0, 16'd0, 8'd0, 8'd0, 16'd0);
				default: program_regs(12'($urandom_range(0, 300)),
					16'($urandom_range(8000, 20000)), 12'($urandom_range(0, 300)),
					16'($urandom_range(16000, 30000)), pick_gain(), pick_gain(),
					16'($urandom_range(10000, 30000)));
			endcase
			run_random(PHASE_ITEMS);
			drain();
		end

		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
